// ----- rtl/core/tkvs_pkg.sv -----
package tkvs_pkg;

  localparam int unsigned MAX_ROW = 256;
  localparam int unsigned MAX_K   = 64;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ROW_AW  = $clog2(MAX_ROW);
  localparam int unsigned LEN_W   = ROW_AW + 1;
  localparam int unsigned K_W     = $clog2(MAX_K) + 1;
  localparam int unsigned KI_W    = (MAX_K > 1) ? $clog2(MAX_K) : 1;

  // register index of top_count
  localparam logic REG_TOP_COUNT = 1'b0;

  typedef enum logic [1:0] {
    S_LOAD,
    S_THR,
    S_SCAN,
    S_PAD
  } state_e;

  typedef struct packed {
    logic ins;
    logic clr;
  } chain_ctrl_t;

  // clamp k into 1..MAX_K
  function automatic logic [K_W-1:0] eff_k(input logic [6:0] cnt);
    logic [K_W-1:0] k;
    if (cnt == 7'd0) begin
      k = K_W'(1);
    end else if ({1'b0, cnt} > 8'(MAX_K)) begin
      k = K_W'(MAX_K);
    end else begin
      k = K_W'(cnt);
    end
    return k;
  endfunction

endpackage

// ----- rtl/core/tkvs_ram.sv -----
module tkvs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/tkvs_cell.sv -----
module tkvs_cell import tkvs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  chain_ctrl_t              ctrl_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic signed [DATA_W-1:0] prev_val_i,
  input  logic                     prev_vld_i,
  input  logic                     prev_ge_i,
  output logic signed [DATA_W-1:0] val_o,
  output logic                     vld_o,
  output logic                     ge_o
);

  logic signed [DATA_W-1:0] val_q, val_d;
  logic                     vld_q, vld_d;
  logic                     ge;

  // this cell keeps its entry when it already ranks at or above the new value
  assign ge = vld_q && (val_q >= value_i);

  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    if (ctrl_i.clr) begin
      vld_d = 1'b0;
    end else if (ctrl_i.ins && !ge) begin
      if (prev_ge_i) begin
        val_d = value_i;
        vld_d = 1'b1;
      end else begin
        val_d = prev_val_i;
        vld_d = prev_vld_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign vld_o = vld_q;
  assign ge_o  = ge;

endmodule

// ----- rtl/core/tkvs_chain.sv -----
module tkvs_chain import tkvs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  chain_ctrl_t              ctrl_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [KI_W-1:0]          sel_i,
  output logic signed [DATA_W-1:0] sel_val_o,
  output logic [MAX_K-1:0]         vld_o
);

  logic signed [DATA_W-1:0] vals [MAX_K];
  logic [MAX_K-1:0]         vld;
  logic [MAX_K-1:0]         ge;

  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    if (i == 0) begin : g_head
      tkvs_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (ctrl_i),
        .value_i    (value_i),
        .prev_val_i (value_i),
        .prev_vld_i (1'b1),
        .prev_ge_i  (1'b1),
        .val_o      (vals[i]),
        .vld_o      (vld[i]),
        .ge_o       (ge[i])
      );
    end else begin : g_body
      tkvs_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (ctrl_i),
        .value_i    (value_i),
        .prev_val_i (vals[i-1]),
        .prev_vld_i (vld[i-1]),
        .prev_ge_i  (ge[i-1]),
        .val_o      (vals[i]),
        .vld_o      (vld[i]),
        .ge_o       (ge[i])
      );
    end
  end

  assign sel_val_o = vals[sel_i];
  assign vld_o     = vld;

endmodule

// ----- rtl/core/top_k_value_select.sv -----
// channel   dir  payload                          handshake
// s_axis    in   tdata = value[31:0], tlast = last  tvalid / tready
// m_axis    out  tdata = value_res[31:0], tlast = last_res  tvalid / tready
// apb       in   top_count at byte address 0       psel / penable, pready = 1
//
// while a row loads, the sorted cell chain takes one insert a cycle
// at row end: the threshold is latched, then stored values are read back one at a time
// from the row ram (registered read) until k results are out; when the row is used up first,
// the block switches to padding and then sends one zero pad per missing result
// no input item is taken while a row is being emitted; a stalled m_axis holds the scan
// reset clears control state and the chain valid bits; row ram contents are left as is
module top_k_value_select import tkvs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] value_res
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_e state_q, state_d;

  logic [6:0]              top_count_q;
  logic [LEN_W-1:0]        len_q, len_d;
  logic [LEN_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [K_W-1:0]          cnt_q, cnt_d;
  logic                    pend_q, pend_d;
  logic signed [DATA_W-1:0] thr_q, thr_d;
  logic                    pass_all_q, pass_all_d;
  logic                    out_valid_q, out_valid_d;
  logic [DATA_W-1:0]       out_data_q, out_data_d;
  logic                    out_last_q, out_last_d;

  logic                    in_acc;
  logic                    out_free;
  logic [K_W-1:0]          k_eff;
  logic                    ram_we;
  logic                    ram_re;
  logic [DATA_W-1:0]       ram_rdata;
  chain_ctrl_t             chain_ctrl;
  logic signed [DATA_W-1:0] chain_sel;
  logic [MAX_K-1:0]        chain_vld;
  logic                    cfg_wr;
  logic                    last_out;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TOP_COUNT);
  assign prdata = (paddr[2] == REG_TOP_COUNT) ? {25'd0, top_count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_count_q <= 7'd1;
    end else if (cfg_wr) begin
      top_count_q <= pwdata[6:0];
    end
  end

  assign k_eff    = eff_k(top_count_q);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign last_out = (cnt_q + K_W'(1)) == k_eff;

  assign s_axis_tready = (state_q == S_LOAD);
  assign ram_we        = in_acc && (len_q < LEN_W'(MAX_ROW));

  tkvs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ROW)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (len_q[ROW_AW-1:0]),
    .wdata_i (s_axis_tdata),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q[ROW_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  tkvs_chain u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (chain_ctrl),
    .value_i   ($signed(s_axis_tdata)),
    .sel_i     (KI_W'(k_eff - K_W'(1))),
    .sel_val_o (chain_sel),
    .vld_o     (chain_vld)
  );

  always_comb begin
    state_d        = state_q;
    len_d          = len_q;
    rd_ptr_d       = rd_ptr_q;
    cnt_d          = cnt_q;
    pend_d         = 1'b0;
    thr_d          = thr_q;
    pass_all_d     = pass_all_q;
    out_valid_d    = out_valid_q && !m_axis_tready;
    out_data_d     = out_data_q;
    out_last_d     = out_last_q;
    ram_re         = 1'b0;
    chain_ctrl.ins = ram_we;
    chain_ctrl.clr = 1'b0;

    case (state_q)
      S_LOAD: begin
        if (ram_we) begin
          len_d = len_q + LEN_W'(1);
        end
        if (in_acc && s_axis_tlast) begin
          state_d = S_THR;
        end
      end
      S_THR: begin
        thr_d      = chain_sel;
        pass_all_d = len_q <= LEN_W'(k_eff);
        rd_ptr_d   = '0;
        cnt_d      = '0;
        state_d    = S_SCAN;
      end
      S_SCAN: begin
        if (pend_q) begin
          // out register is known free here: the read was issued only when it was
          if (pass_all_q || ($signed(ram_rdata) >= thr_q)) begin
            out_valid_d = 1'b1;
            out_data_d  = ram_rdata;
            out_last_d  = last_out;
            cnt_d       = cnt_q + K_W'(1);
            if (last_out) begin
              state_d        = S_LOAD;
              len_d          = '0;
              chain_ctrl.clr = 1'b1;
            end
          end
        end else if (rd_ptr_q == len_q) begin
          state_d = S_PAD;
        end else if (out_free) begin
          ram_re   = 1'b1;
          rd_ptr_d = rd_ptr_q + LEN_W'(1);
          pend_d   = 1'b1;
        end
      end
      S_PAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          out_last_d  = last_out;
          cnt_d       = cnt_q + K_W'(1);
          if (last_out) begin
            state_d        = S_LOAD;
            len_d          = '0;
            chain_ctrl.clr = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      len_q       <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      pass_all_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      rd_ptr_q    <= rd_ptr_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      pass_all_q  <= pass_all_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    thr_q      <= thr_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // a pending ram read only exists during the scan
  a_pend_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_SCAN))
    else $error("ram read pending outside scan");

  // read data never lands on an occupied out register
  a_pend_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !out_valid_q)
    else $error("read data arrived while out register busy");

  // chain valid bits always form a run from the head
  a_chain_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain_vld & (chain_vld + MAX_K'(1))) == '0)
    else $error("chain valid bits not contiguous");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(MAX_ROW))
    else $error("row length beyond store depth");

endmodule
